FILE: design/dsrs_pkg.sv
package dsrs_pkg;

    // default sizes
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TRACK_BITS_DEF  = 12;

    // fixed field widths
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;
    localparam int TAG_BITS       = 8;
    localparam int SUM_BITS       = 24;
    localparam int COUNT_BITS     = 16;

    localparam logic [CFG_DATA_BITS-1:0] START_RESET = CFG_DATA_BITS'(90);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START = 2'd1;

    // policy codes, code 3 is served as first come first served
    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SSTF = 2'd1;
    localparam logic [1:0] MODE_LOOK = 2'd2;

    // commands
    localparam logic CMD_ENQUEUE  = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_ENQUEUED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_SERVED   = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    // control into the compare unit
    typedef struct packed {
        logic [1:0] mode;
        logic       sweep_up;
        logic       best_vld;
    } pick_ctrl_t;

endpackage

FILE: design/disk_seek_request_scheduler.sv
// channel   | signals                                        | handshake
// ----------+------------------------------------------------+----------------------------
// request   | command, request_id, track                     | start && !busy
// result    | status, served_id, served_track, seek_distance,| result_valid, one cycle,
//           | total_distance, served_count                   | no back-pressure
// config    | cfg_index, cfg_wdata                           | cfg_valid && cfg_ready
//
// an enqueue or an empty dispatch leaves busy low: the result shows the next cycle
// a serving dispatch keeps busy high through scan, shift and finish (fcfs scans only
// the oldest entry), one queue read per cycle through the single read port, a second
// scan when the elevator turns, and a close-up of the queue behind the removed entry
// results cannot be stalled by the receiver; the result shows once busy drops
// reset is asynchronous active low; the queue contents are not cleared, only its length
module disk_seek_request_scheduler #(
    parameter int QUEUE_DEPTH = dsrs_pkg::QUEUE_DEPTH_DEF,
    parameter int TRACK_BITS  = dsrs_pkg::TRACK_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 command,
    input  logic [dsrs_pkg::TAG_BITS-1:0]        request_id,
    input  logic [TRACK_BITS-1:0]                track,
    // result channel
    output logic                                 result_valid,
    output logic [1:0]                           status,
    output logic [dsrs_pkg::TAG_BITS-1:0]        served_id,
    output logic [TRACK_BITS-1:0]                served_track,
    output logic [TRACK_BITS-1:0]                seek_distance,
    output logic [dsrs_pkg::SUM_BITS-1:0]        total_distance,
    output logic [dsrs_pkg::COUNT_BITS-1:0]      served_count,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dsrs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dsrs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
    localparam int LEN_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int TB       = dsrs_pkg::TAG_BITS;
    localparam int SB       = dsrs_pkg::SUM_BITS;
    localparam int CB       = dsrs_pkg::COUNT_BITS;
    localparam logic [LEN_BITS-1:0] LEN_FULL = LEN_BITS'(QUEUE_DEPTH);
    localparam logic [SB-1:0] SUM_MAX   = {SB{1'b1}};
    localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

    // idle, scan the queue for the pick, close up the queue, report
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [1:0]            mode_reg, mode_next;
    logic [TRACK_BITS-1:0] head_reg, head_next;
    logic                  sweep_reg, sweep_next;
    logic [SB-1:0]         sum_reg, sum_next;
    logic [CB-1:0]         count_reg, count_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic [LEN_BITS-1:0]   cnt_reg, cnt_next;
    logic                  vld_reg, vld_next;
    logic [IDX_BITS-1:0]   pidx_reg, pidx_next;
    logic                  pass2_reg, pass2_next;
    logic                  best_vld_reg, best_vld_next;
    logic [IDX_BITS-1:0]   best_idx_reg, best_idx_next;
    logic [TRACK_BITS-1:0] best_track_reg, best_track_next;
    logic [TB-1:0]         best_tag_reg, best_tag_next;
    logic                  strobe_reg, strobe_next;
    logic [1:0]            status_reg, status_next;
    logic [TB-1:0]         sid_reg, sid_next;
    logic [TRACK_BITS-1:0] dist_reg, dist_next;

    // queue memory ports
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [TRACK_BITS-1:0] wr_track;
    logic [TB-1:0]         wr_tag;
    logic [TRACK_BITS-1:0] rd_track;
    logic [TB-1:0]         rd_tag;

    // compare unit
    dsrs_pkg::pick_ctrl_t  pick_ctrl;
    logic [TRACK_BITS-1:0] cand;
    logic                  take;
    logic [TRACK_BITS-1:0] cand_gap;

    logic                  accept;
    logic                  is_fcfs;
    logic [LEN_BITS-1:0]   scan_lim;
    logic [SB:0]           sum_wide;

    dsrs_queue #(
        .DEPTH      (QUEUE_DEPTH),
        .TRACK_BITS (TRACK_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_queue (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_track (wr_track),
        .wr_tag   (wr_tag),
        .rd_addr  (cnt_reg[IDX_BITS-1:0]),
        .rd_track (rd_track),
        .rd_tag   (rd_tag)
    );

    dsrs_cmp #(
        .TRACK_BITS (TRACK_BITS)
    ) u_cmp (
        .ctrl     (pick_ctrl),
        .head     (head_reg),
        .cand     (cand),
        .best     (best_track_reg),
        .take     (take),
        .cand_gap (cand_gap)
    );

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign pick_ctrl.mode     = mode_reg;
    assign pick_ctrl.sweep_up = sweep_reg;
    assign pick_ctrl.best_vld = best_vld_reg;

    // the compare unit doubles as the seek distance subtractor at the end
    assign cand = (state_reg == S_FINISH) ? best_track_reg : rd_track;

    // fcfs (and the unused code) only needs the oldest entry
    assign is_fcfs  = (mode_reg != dsrs_pkg::MODE_SSTF) && (mode_reg != dsrs_pkg::MODE_LOOK);
    assign scan_lim = is_fcfs ? LEN_BITS'(1) : len_reg;

    assign sum_wide = {1'b0, sum_reg} + (SB + 1)'(cand_gap);

    // memory writes: append on enqueue, close-up during shift
    always_comb
    begin
        if (state_reg == S_SHIFT)
        begin
            wr_en    = vld_reg;
            wr_addr  = pidx_reg - IDX_BITS'(1);
            wr_track = rd_track;
            wr_tag   = rd_tag;
        end
        else
        begin
            wr_en    = accept && (command == dsrs_pkg::CMD_ENQUEUE) && (len_reg != LEN_FULL);
            wr_addr  = len_reg[IDX_BITS-1:0];
            wr_track = track;
            wr_tag   = request_id;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        head_next       = head_reg;
        sweep_next      = sweep_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        len_next        = len_reg;
        cnt_next        = cnt_reg;
        vld_next        = 1'b0;
        pidx_next       = cnt_reg[IDX_BITS-1:0];
        pass2_next      = pass2_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_track_next = best_track_reg;
        best_tag_next   = best_tag_reg;
        strobe_next     = 1'b0;
        status_next     = status_reg;
        sid_next        = sid_reg;
        dist_next       = dist_reg;

        // config writes are for the user to send only while idle; the block itself does not enforce it
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dsrs_pkg::REG_MODE:
                    mode_next = cfg_wdata[1:0];
                dsrs_pkg::REG_START:
                    if (count_reg == '0)
                        head_next = TRACK_BITS'(cfg_wdata);
                default:
                    ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sid_next  = '0;
                    dist_next = '0;
                    if (command == dsrs_pkg::CMD_ENQUEUE)
                    begin
                        strobe_next = 1'b1;
                        if (len_reg == LEN_FULL)
                            status_next = dsrs_pkg::STAT_FULL;
                        else
                        begin
                            status_next = dsrs_pkg::STAT_ENQUEUED;
                            len_next    = len_reg + LEN_BITS'(1);
                        end
                    end
                    else if (len_reg == '0)
                    begin
                        strobe_next = 1'b1;
                        status_next = dsrs_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        state_next    = S_SCAN;
                        cnt_next      = '0;
                        best_vld_next = 1'b0;
                        pass2_next    = 1'b0;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read a cycle, judge the data of the previous one
                if (cnt_reg != scan_lim)
                begin
                    cnt_next = cnt_reg + LEN_BITS'(1);
                    vld_next = 1'b1;
                end
                if (vld_reg && take)
                begin
                    best_vld_next   = 1'b1;
                    best_idx_next   = pidx_reg;
                    best_track_next = rd_track;
                    best_tag_next   = rd_tag;
                end
                if ((cnt_reg == scan_lim) && !vld_reg)
                begin
                    // nothing ahead of the sweep: turn and look the other way
                    // (every track lies on one side, so the second pass finds one)
                    if ((mode_reg == dsrs_pkg::MODE_LOOK) && !best_vld_reg && !pass2_reg)
                    begin
                        sweep_next = !sweep_reg;
                        pass2_next = 1'b1;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                        cnt_next   = LEN_BITS'(best_idx_reg) + LEN_BITS'(1);
                    end
                end
            end

            S_SHIFT:
            begin
                // read entry i+1, write it to i on the next cycle
                if (cnt_reg != len_reg)
                begin
                    cnt_next = cnt_reg + LEN_BITS'(1);
                    vld_next = 1'b1;
                end
                else if (!vld_reg)
                    state_next = S_FINISH;
            end

            S_FINISH:
            begin
                state_next  = S_IDLE;
                strobe_next = 1'b1;
                status_next = dsrs_pkg::STAT_SERVED;
                sid_next    = best_tag_reg;
                dist_next   = cand_gap;
                head_next   = best_track_reg;
                len_next    = len_reg - LEN_BITS'(1);
                sum_next    = sum_wide[SB] ? SUM_MAX : sum_wide[SB-1:0];
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + CB'(1);
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= dsrs_pkg::MODE_FCFS;
            head_reg     <= TRACK_BITS'(dsrs_pkg::START_RESET);
            sweep_reg    <= 1'b1;
            sum_reg      <= '0;
            count_reg    <= '0;
            len_reg      <= '0;
            cnt_reg      <= '0;
            vld_reg      <= 1'b0;
            pass2_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            head_reg     <= head_next;
            sweep_reg    <= sweep_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            vld_reg      <= vld_next;
            pass2_reg    <= pass2_next;
            best_vld_reg <= best_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg       <= pidx_next;
        best_idx_reg   <= best_idx_next;
        best_track_reg <= best_track_next;
        best_tag_reg   <= best_tag_next;
        status_reg     <= status_next;
        sid_reg        <= sid_next;
        dist_reg       <= dist_next;
    end

    assign result_valid   = strobe_reg;
    assign status         = status_reg;
    assign served_id      = sid_reg;
    assign served_track   = head_reg;
    assign seek_distance  = dist_reg;
    assign total_distance = sum_reg;
    assign served_count   = count_reg;

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n) len_reg <= LEN_FULL)
        else $error("queue length beyond depth");

    // an enqueue with room reports enqueued on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (command == dsrs_pkg::CMD_ENQUEUE) && (len_reg != LEN_FULL)
        |=> result_valid && (status == dsrs_pkg::STAT_ENQUEUED))
        else $error("enqueue result missing");

    // a dispatch on a non-empty queue holds the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (command == dsrs_pkg::CMD_DISPATCH) && (len_reg != '0) |=> busy)
        else $error("dispatch did not start");

    // results only leave while idle
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> !busy)
        else $error("result while busy");

    // a serve always finds a pick
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> best_vld_reg)
        else $error("dispatch without a pick");

endmodule

FILE: design/dsrs_queue.sv
module dsrs_queue #(
    parameter int DEPTH      = dsrs_pkg::QUEUE_DEPTH_DEF,
    parameter int TRACK_BITS = dsrs_pkg::TRACK_BITS_DEF,
    parameter int IDX_BITS   = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [IDX_BITS-1:0]          wr_addr,
    input  logic [TRACK_BITS-1:0]        wr_track,
    input  logic [dsrs_pkg::TAG_BITS-1:0] wr_tag,
    input  logic [IDX_BITS-1:0]          rd_addr,
    output logic [TRACK_BITS-1:0]        rd_track,
    output logic [dsrs_pkg::TAG_BITS-1:0] rd_tag
);

    logic [TRACK_BITS-1:0]         track_mem [DEPTH];
    logic [dsrs_pkg::TAG_BITS-1:0] tag_mem   [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            track_mem[wr_addr] <= wr_track;
            tag_mem[wr_addr]   <= wr_tag;
        end
        rd_track <= track_mem[rd_addr];
        rd_tag   <= tag_mem[rd_addr];
    end

endmodule

FILE: design/dsrs_cmp.sv
module dsrs_cmp #(
    parameter int TRACK_BITS = dsrs_pkg::TRACK_BITS_DEF
) (
    input  dsrs_pkg::pick_ctrl_t   ctrl,
    input  logic [TRACK_BITS-1:0]  head,
    input  logic [TRACK_BITS-1:0]  cand,
    input  logic [TRACK_BITS-1:0]  best,
    output logic                   take,
    output logic [TRACK_BITS-1:0]  cand_gap
);

    logic [TRACK_BITS-1:0] best_gap;
    logic                  cand_ge;
    logic                  cand_le;

    assign cand_ge  = cand >= head;
    assign cand_le  = cand <= head;
    assign cand_gap = cand_ge ? cand - head : head - cand;
    assign best_gap = (best >= head) ? best - head : head - best;

    always_comb
    begin
        case (ctrl.mode)
            dsrs_pkg::MODE_SSTF:
                take = !ctrl.best_vld || (cand_gap < best_gap) ||
                       ((cand_gap == best_gap) && (cand > best));
            dsrs_pkg::MODE_LOOK:
                if (ctrl.sweep_up)
                    take = cand_ge && (!ctrl.best_vld || (cand < best));
                else
                    take = cand_le && (!ctrl.best_vld || (cand > best));
            default:
                take = !ctrl.best_vld;
        endcase
    end

endmodule
